// File: hw/rtl/mhpp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mhpp_pkg
// Shared widths, constants and types of the multichannel high-pass packetizer.
// ----------------------------------------------------------------------------
package mhpp_pkg;

   localparam int CHANNELS       = 6;
   localparam int SAMPLE_BITS    = 12;
   localparam int ALPHA_BITS     = 16;
   localparam int HEADER_BITS    = 8;
   localparam int RESULT_BITS    = 16;
   localparam int BYTE_BITS      = 8;
   localparam int FRAC_BITS      = 16;
   localparam int STATE_BITS     = 32;
   localparam int SUM_BITS       = STATE_BITS + 2;
   localparam int PROD_BITS      = SUM_BITS + ALPHA_BITS + 1;
   localparam int PACKET_LEN     = 1 + 2 * CHANNELS;
   localparam int COUNT_BITS     = $clog2(PACKET_LEN + 1);
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 16;

   localparam logic [ALPHA_BITS-1:0]  ALPHA_RESET  = 16'd65339;
   localparam logic [HEADER_BITS-1:0] HEADER_RESET = 8'hAA;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_ALPHA  = 2'd0,
      CSR_HEADER = 2'd1
   } csr_index_type;

   typedef struct packed {
      logic take;     // load sample, register product
      logic advance;  // commit filter state, register result
   } lane_ctrl_type;

endpackage
`default_nettype wire

// File: hw/rtl/mhpp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mhpp_req_if / mhpp_rsp_if
// Valid/ready channels: sample frames in, packet bytes out.
// ----------------------------------------------------------------------------
interface mhpp_req_if;
   logic                             valid;
   logic                             ready;
   logic [mhpp_pkg::SAMPLE_BITS-1:0] sample_ch0;
   logic [mhpp_pkg::SAMPLE_BITS-1:0] sample_ch1;
   logic [mhpp_pkg::SAMPLE_BITS-1:0] sample_ch2;
   logic [mhpp_pkg::SAMPLE_BITS-1:0] sample_ch3;
   logic [mhpp_pkg::SAMPLE_BITS-1:0] sample_ch4;
   logic [mhpp_pkg::SAMPLE_BITS-1:0] sample_ch5;

   modport source (output valid, sample_ch0, sample_ch1, sample_ch2, sample_ch3,
                   sample_ch4, sample_ch5, input ready);
   modport sink (input valid, sample_ch0, sample_ch1, sample_ch2, sample_ch3,
                 sample_ch4, sample_ch5, output ready);
endinterface

interface mhpp_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [mhpp_pkg::BYTE_BITS-1:0] packet_byte;
   logic                           last_byte;

   modport source (output valid, packet_byte, last_byte, input ready);
   modport sink (input valid, packet_byte, last_byte, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/mhpp_lane.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mhpp_lane
// One channel of the first-order high-pass filter, Q16.16 state, int16 result.
// ----------------------------------------------------------------------------
module mhpp_lane (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire mhpp_pkg::lane_ctrl_type           ctrl,
   input  wire logic [mhpp_pkg::ALPHA_BITS-1:0]   alpha,
   input  wire logic [mhpp_pkg::SAMPLE_BITS-1:0]  sample,
   output logic [mhpp_pkg::RESULT_BITS-1:0]       result
);

   logic        [mhpp_pkg::SAMPLE_BITS-1:0] prev_in_ff, prev_in_in;
   logic signed [mhpp_pkg::STATE_BITS-1:0]  prev_out_ff, prev_out_in;
   logic signed [mhpp_pkg::PROD_BITS-1:0]   prod_ff, prod_in;
   logic        [mhpp_pkg::RESULT_BITS-1:0] result_ff, result_in;

   logic signed [mhpp_pkg::SAMPLE_BITS:0]   diff;
   logic signed [mhpp_pkg::SUM_BITS-1:0]    sum;
   logic signed [mhpp_pkg::PROD_BITS-1:0]   prod_rnd;
   logic signed [mhpp_pkg::PROD_BITS-1:0]   y_wide;
   logic signed [mhpp_pkg::STATE_BITS-1:0]  y_sat;
   logic signed [mhpp_pkg::STATE_BITS:0]    y_rnd;
   logic                                    y_fits;

   always_comb begin
      diff = $signed({1'b0, sample}) - $signed({1'b0, prev_in_ff});
      sum  = mhpp_pkg::SUM_BITS'(prev_out_ff)
           + (mhpp_pkg::SUM_BITS'(diff) <<< mhpp_pkg::FRAC_BITS);
      prod_in = $signed({1'b0, alpha}) * sum;

      // truncate toward zero
      prod_rnd = prod_ff + (prod_ff[mhpp_pkg::PROD_BITS-1]
                 ? mhpp_pkg::PROD_BITS'((1 << mhpp_pkg::FRAC_BITS) - 1)
                 : mhpp_pkg::PROD_BITS'(0));
      y_wide   = prod_rnd >>> mhpp_pkg::FRAC_BITS;
      y_fits   = (&y_wide[mhpp_pkg::PROD_BITS-1:mhpp_pkg::STATE_BITS-1])
              || (~|y_wide[mhpp_pkg::PROD_BITS-1:mhpp_pkg::STATE_BITS-1]);
      if (y_fits) begin
         y_sat = y_wide[mhpp_pkg::STATE_BITS-1:0];
      end else if (y_wide[mhpp_pkg::PROD_BITS-1]) begin
         y_sat = {1'b1, {(mhpp_pkg::STATE_BITS-1){1'b0}}};
      end else begin
         y_sat = {1'b0, {(mhpp_pkg::STATE_BITS-1){1'b1}}};
      end

      y_rnd = (mhpp_pkg::STATE_BITS+1)'(y_sat) + (y_sat[mhpp_pkg::STATE_BITS-1]
              ? (mhpp_pkg::STATE_BITS+1)'((1 << mhpp_pkg::FRAC_BITS) - 1)
              : (mhpp_pkg::STATE_BITS+1)'(0));

      prev_in_in  = ctrl.take ? sample : prev_in_ff;
      prev_out_in = ctrl.advance ? y_sat : prev_out_ff;
      result_in   = ctrl.advance
                  ? y_rnd[mhpp_pkg::STATE_BITS-1:mhpp_pkg::FRAC_BITS] : result_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_in_ff  <= '0;
         prev_out_ff <= '0;
      end else begin
         prev_in_ff  <= prev_in_in;
         prev_out_ff <= prev_out_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.take) begin
         prod_ff <= prod_in;
      end
      result_ff <= result_in;
   end

   assign result = result_ff;

endmodule
`default_nettype wire

// File: hw/rtl/mhpp_packer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mhpp_packer
// Merges the lane results into a 13-word packet and sends one word per cycle while rsp.ready is high.
// ----------------------------------------------------------------------------
module mhpp_packer (
   input  wire logic                                                  clock,
   input  wire logic                                                  reset,
   input  wire logic                                                  load,
   input  wire logic [mhpp_pkg::HEADER_BITS-1:0]                      header,
   input  wire logic [mhpp_pkg::CHANNELS-1:0][mhpp_pkg::RESULT_BITS-1:0] results,
   output logic                                                       free,
   mhpp_rsp_if.source                                                 rsp
);

   logic [mhpp_pkg::COUNT_BITS-1:0]                   count_ff, count_in;
   logic [mhpp_pkg::PACKET_LEN-1:0][mhpp_pkg::BYTE_BITS-1:0] words_ff, words_in;
   logic                                              take;

   always_comb begin
      take = rsp.valid && rsp.ready;
      free = (count_ff == '0)
          || ((count_ff == mhpp_pkg::COUNT_BITS'(1)) && rsp.ready);
      count_in = count_ff;
      words_in = words_ff;
      if (load) begin
         count_in    = mhpp_pkg::COUNT_BITS'(mhpp_pkg::PACKET_LEN);
         words_in[0] = header;
         for (int c = 0; c < mhpp_pkg::CHANNELS; c++) begin
            words_in[1 + 2 * c] = results[c][mhpp_pkg::BYTE_BITS-1:0];
            words_in[2 + 2 * c] = results[c][mhpp_pkg::RESULT_BITS-1:mhpp_pkg::BYTE_BITS];
         end
      end else if (take) begin
         count_in = count_ff - mhpp_pkg::COUNT_BITS'(1);
         words_in = words_ff >> mhpp_pkg::BYTE_BITS;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      words_ff <= words_in;
   end

   assign rsp.valid       = (count_ff != '0);
   assign rsp.packet_byte = words_ff[0];
   assign rsp.last_byte   = (count_ff == mhpp_pkg::COUNT_BITS'(1));

endmodule
`default_nettype wire

// File: hw/rtl/multichannel_highpass_packetizer_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// multichannel_highpass_packetizer_core
// Six-channel first-order high-pass filter with a byte packetizer.
// ----------------------------------------------------------------------------
// req: one word carries six 12-bit ADC samples (sample_ch0..sample_ch5).
// rsp: 13 words per frame: header byte, then each channel's int16 result,
//      low byte then high byte; last_byte marks the thirteenth word.
// csr: csr_we/csr_index/csr_wdata; index 0 = alpha (Q0.16), 1 = header byte.
//      Unknown indexes are ignored. Write only while the block is idle.
// Six lanes filter the channels in parallel: the product alpha*(y+x-xp) is
// registered on acceptance, state and result when the result stage is free.
// The header word is valid once the packer has loaded the results, and words
// follow one per cycle while rsp.ready is high; that output sets the frame
// throughput. A second frame is accepted while a packet is still being sent;
// it waits in the lane result registers, and a third waits in the multiply
// stage with req.ready low until the lanes free up.
// A stalled receiver holds the current word; nothing is dropped.
// Reset clears filter state to zero and restores the register defaults.
// ----------------------------------------------------------------------------
module multichannel_highpass_packetizer_core (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   mhpp_req_if.sink                                   req,
   mhpp_rsp_if.source                                 rsp,
   input  wire logic                                  csr_we,
   input  wire logic [mhpp_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  wire logic [mhpp_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);

   logic [mhpp_pkg::ALPHA_BITS-1:0]  alpha_ff, alpha_in;
   logic [mhpp_pkg::HEADER_BITS-1:0] header_ff, header_in;
   logic                             p1_ff, p1_in;
   logic                             p2_ff, p2_in;
   logic                             load;
   logic                             packer_free;
   mhpp_pkg::lane_ctrl_type          lane_ctrl;

   logic [mhpp_pkg::CHANNELS-1:0][mhpp_pkg::SAMPLE_BITS-1:0] samples;
   logic [mhpp_pkg::CHANNELS-1:0][mhpp_pkg::RESULT_BITS-1:0] results;

   assign samples[0] = req.sample_ch0;
   assign samples[1] = req.sample_ch1;
   assign samples[2] = req.sample_ch2;
   assign samples[3] = req.sample_ch3;
   assign samples[4] = req.sample_ch4;
   assign samples[5] = req.sample_ch5;

   always_comb begin
      alpha_in  = alpha_ff;
      header_in = header_ff;
      if (csr_we) begin
         case (csr_index)
            mhpp_pkg::CSR_ALPHA: begin
               alpha_in = csr_wdata[mhpp_pkg::ALPHA_BITS-1:0];
            end
            mhpp_pkg::CSR_HEADER: begin
               header_in = csr_wdata[mhpp_pkg::HEADER_BITS-1:0];
            end
            default: begin
               alpha_in = alpha_ff;
            end
         endcase
      end
   end

   always_comb begin
      req.ready         = !p1_ff;
      load              = p2_ff && packer_free;
      lane_ctrl.take    = req.valid && !p1_ff;
      lane_ctrl.advance = p1_ff && (!p2_ff || load);
      p1_in = lane_ctrl.take ? 1'b1 : (lane_ctrl.advance ? 1'b0 : p1_ff);
      p2_in = lane_ctrl.advance ? 1'b1 : (load ? 1'b0 : p2_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff  <= mhpp_pkg::ALPHA_RESET;
         header_ff <= mhpp_pkg::HEADER_RESET;
         p1_ff     <= 1'b0;
         p2_ff     <= 1'b0;
      end else begin
         alpha_ff  <= alpha_in;
         header_ff <= header_in;
         p1_ff     <= p1_in;
         p2_ff     <= p2_in;
      end
   end

   for (genvar c = 0; c < mhpp_pkg::CHANNELS; c++) begin : g_lane
      mhpp_lane u_lane (
         .clock  (clock),
         .reset  (reset),
         .ctrl   (lane_ctrl),
         .alpha  (alpha_ff),
         .sample (samples[c]),
         .result (results[c])
      );
   end

   mhpp_packer u_packer (
      .clock   (clock),
      .reset   (reset),
      .load    (load),
      .header  (header_ff),
      .results (results),
      .free    (packer_free),
      .rsp     (rsp)
   );

   // a frame in the multiply stage only moves on into the result stage
   a_p1_to_p2: assert property (@(posedge clock) disable iff (reset)
      p1_ff |=> (p1_ff || p2_ff))
      else $error("frame lost from multiply stage");

   // a waiting result is held until the packer takes it
   a_p2_hold: assert property (@(posedge clock) disable iff (reset)
      (p2_ff && !load) |=> p2_ff)
      else $error("frame lost from result stage");

   // a packet always opens with the header word
   a_header_first: assert property (@(posedge clock) disable iff (reset)
      load |=> (rsp.valid && !rsp.last_byte && rsp.packet_byte == $past(header_ff)))
      else $error("packet does not start with header");

endmodule
`default_nettype wire

// File: bench/multichannel_highpass_packetizer_core_filter_check.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// multichannel_highpass_packetizer_core_filter_check
// Watches the CSR port and both channels of the packetizer. It keeps its own
// six-lane Q16.16 high-pass state, expands each accepted sample frame into
// the 13 packet words it should produce, and compares every word that
// leaves the block, in order, against them.
// ----------------------------------------------------------------------------
module multichannel_highpass_packetizer_core_filter_check
   import mhpp_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   mhpp_req_if                            req,
   mhpp_rsp_if                            rsp,
   input  wire logic                      csr_we,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_wdata,
   output int                             fault_count,
   output int                             words_due,
   output int                             words_checked,
   output int                             frames_taken
);

   localparam longint UNITY  = longint'(1) << FRAC_BITS;
   localparam longint Y_MAX  = 64'sh7FFF_FFFF;
   localparam longint Y_MIN  = -64'sh8000_0000;
   localparam int     PRINT_CAP = 40;

   typedef struct packed {
      logic [BYTE_BITS-1:0] packet_byte;
      logic                 last_byte;
   } packet_word_type;

   packet_word_type               bytes_due[$];
   logic [ALPHA_BITS-1:0]         alpha;
   logic [HEADER_BITS-1:0]        header;
   logic signed [STATE_BITS-1:0]  filter_y [CHANNELS];
   logic [SAMPLE_BITS-1:0]        filter_x [CHANNELS];

   task automatic report_mismatch(input string detail);
      if (fault_count < PRINT_CAP)
         $display("[%0t] packet mismatch: %s", $time, detail);
      fault_count++;
   endtask

   always @(posedge clock) begin
      logic [SAMPLE_BITS-1:0] frame [CHANNELS];
      packet_word_type        due;
      longint                 gain, x_now, x_prev, y_prev, y_new, result;

      if (reset) begin
         alpha = ALPHA_RESET;
         header = HEADER_RESET;
         for (int c = 0; c < CHANNELS; c++) begin
            filter_y[c] = '0;
            filter_x[c] = '0;
         end
         bytes_due.delete();
         fault_count = 0;
         words_checked = 0;
         frames_taken = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_ALPHA:  alpha = csr_wdata[ALPHA_BITS-1:0];
               CSR_HEADER: header = csr_wdata[HEADER_BITS-1:0];
               default: ;
            endcase
         end

         if (req.valid && req.ready) begin
            frame = '{req.sample_ch0, req.sample_ch1, req.sample_ch2,
                      req.sample_ch3, req.sample_ch4, req.sample_ch5};
            bytes_due.push_back(packet_word_type'{header, PACKET_LEN == 1});
            gain = alpha;
            for (int c = 0; c < CHANNELS; c++) begin
               x_now = frame[c];
               x_prev = filter_x[c];
               y_prev = filter_y[c];
               y_new = (gain * (y_prev + (x_now - x_prev) * UNITY)) / UNITY;
               if (y_new > Y_MAX)
                  y_new = Y_MAX;
               else if (y_new < Y_MIN)
                  y_new = Y_MIN;
               filter_y[c] = y_new[STATE_BITS-1:0];
               filter_x[c] = frame[c];
               // int32 scaled down by 2^16 always fits int16
               result = y_new / UNITY;
               bytes_due.push_back(packet_word_type'{result[7:0], 1'b0});
               bytes_due.push_back(packet_word_type'{result[15:8],
                                                  (2 * c + 2) == (PACKET_LEN - 1)});
            end
            frames_taken++;
         end

         if (rsp.valid && rsp.ready) begin
            if (bytes_due.size() == 0) begin
               report_mismatch($sformatf("word 0x%02h last=%0b with no packet pending",
                                         rsp.packet_byte, rsp.last_byte));
            end else begin
               due = bytes_due.pop_front();
               if (rsp.packet_byte !== due.packet_byte)
                  report_mismatch($sformatf("word %0d byte 0x%02h, want 0x%02h",
                                            words_checked, rsp.packet_byte,
                                            due.packet_byte));
               if (rsp.last_byte !== due.last_byte)
                  report_mismatch($sformatf("word %0d last %b, want %b",
                                            words_checked, rsp.last_byte,
                                            due.last_byte));
               words_checked++;
            end
         end
      end
      words_due = bytes_due.size();
   end

endmodule

// File: bench/multichannel_highpass_packetizer_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// multichannel_highpass_packetizer_core_tb
// Drives sample frames in bursts against a stalling packet receiver, under
// several coefficient and header settings including both coefficient
// extremes, and reports the filter checker's verdict.
// ----------------------------------------------------------------------------
module multichannel_highpass_packetizer_core_tb;
   import mhpp_pkg::*;

   localparam int CLOCK_HALF = 4;
   localparam int TIMEOUT_NS = 2_000_000;
   localparam int SAMPLE_MAX = (1 << SAMPLE_BITS) - 1;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNMAPPED_LO = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNMAPPED_HI = 2'd3;

   typedef logic [CHANNELS-1:0][SAMPLE_BITS-1:0] frame_word_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      csr_we;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wdata;

   int             fault_count, words_due, words_checked, frames_taken;
   int             burst_left = 0;
   int             settings_used = 1;
   int             rx_mode = 0;
   int             rx_span = 0;
   frame_word_type last_frame = '0;

   mhpp_req_if req_ch();
   mhpp_rsp_if rsp_ch();

   multichannel_highpass_packetizer_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   multichannel_highpass_packetizer_core_filter_check filter_check (
      .clock         (clock),
      .reset         (reset),
      .req           (req_ch),
      .rsp           (rsp_ch),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fault_count   (fault_count),
      .words_due     (words_due),
      .words_checked (words_checked),
      .frames_taken  (frames_taken)
   );

   always begin
      #(CLOCK_HALF) clock = 1'b1;
      #(CLOCK_HALF) clock = 1'b0;
   end

   // receiver: switches between free-running, random, sparse and periodically gapped ready
   always @(negedge clock) begin
      if (rx_span == 0) begin
         rx_mode = $urandom_range(0, 3);
         rx_span = $urandom_range(8, 80);
      end
      rx_span--;
      case (rx_mode)
         0:       rsp_ch.ready <= 1'b1;
         1:       rsp_ch.ready <= 1'($urandom_range(0, 1));
         2:       rsp_ch.ready <= ($urandom_range(0, 3) == 0);
         default: rsp_ch.ready <= (rx_span % 5) != 0;
      endcase
   end

   task automatic send_frame(input frame_word_type f);
      if (burst_left == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(negedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(15, 40)
                                                  : $urandom_range(1, 6);
      end
      req_ch.valid <= 1'b1;
      req_ch.sample_ch0 <= f[0];
      req_ch.sample_ch1 <= f[1];
      req_ch.sample_ch2 <= f[2];
      req_ch.sample_ch3 <= f[3];
      req_ch.sample_ch4 <= f[4];
      req_ch.sample_ch5 <= f[5];
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      @(negedge clock);
      burst_left--;
      last_frame = f;
   endtask

   // hold the sender until every packet word has come out
   task automatic drain_packets();
      req_ch.valid <= 1'b0;
      burst_left = 0;
      do @(negedge clock); while (words_due != 0);
   endtask

   task automatic set_register(input logic [CSR_INDEX_BITS-1:0] index,
                               input logic [CSR_DATA_BITS-1:0] value);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   function automatic frame_word_type random_frame(input frame_word_type prev);
      frame_word_type f;
      int             v;

      f = prev;
      case ($urandom_range(0, 5))
         3: begin
            for (int c = 0; c < CHANNELS; c++) begin
               v = prev[c];
               v = v + $urandom_range(0, 62) - 31;
               if (v < 0) v = 0;
               if (v > SAMPLE_MAX) v = SAMPLE_MAX;
               f[c] = v[SAMPLE_BITS-1:0];
            end
         end
         4: begin
            for (int c = 0; c < CHANNELS; c++)
               f[c] = $urandom_range(0, 1) ? SAMPLE_MAX[SAMPLE_BITS-1:0] : '0;
         end
         5: f[$urandom_range(0, CHANNELS - 1)] = SAMPLE_BITS'($urandom);
         default: begin
            for (int c = 0; c < CHANNELS; c++)
               f[c] = SAMPLE_BITS'($urandom);
         end
      endcase
      return f;
   endfunction

   initial begin
      #(TIMEOUT_NS);
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      logic [ALPHA_BITS-1:0] alpha_pick;

      req_ch.valid = 1'b0;
      req_ch.sample_ch0 = '0;
      req_ch.sample_ch1 = '0;
      req_ch.sample_ch2 = '0;
      req_ch.sample_ch3 = '0;
      req_ch.sample_ch4 = '0;
      req_ch.sample_ch5 = '0;
      rsp_ch.ready = 1'b0;
      csr_we = 1'b0;
      csr_index = CSR_ALPHA;
      csr_wdata = '0;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset coefficient and header: steps, decay, bit patterns
      send_frame({CHANNELS{12'd0}});
      send_frame({CHANNELS{12'd4095}});
      send_frame({CHANNELS{12'd4095}});
      send_frame({CHANNELS{12'd0}});
      send_frame({12'd4095, 12'd0, 12'd4095, 12'd0, 12'd4095, 12'd0});
      send_frame({12'd0, 12'd4095, 12'd0, 12'd4095, 12'd0, 12'd4095});
      send_frame({12'hAAA, 12'h555, 12'hAAA, 12'h555, 12'hAAA, 12'h555});
      send_frame({12'h555, 12'hAAA, 12'h555, 12'hAAA, 12'h555, 12'hAAA});
      send_frame({12'd3501, 12'd2801, 12'd2101, 12'd1401, 12'd701, 12'd1});
      send_frame({CHANNELS{12'd1}});

      // unity-most coefficient, zero header, writes to unmapped indexes
      drain_packets();
      set_register(CSR_ALPHA, 16'hFFFF);
      set_register(CSR_HEADER, 16'h0000);
      set_register(CSR_UNMAPPED_LO, 16'($urandom));
      set_register(CSR_UNMAPPED_HI, 16'($urandom));
      settings_used++;
      send_frame({CHANNELS{12'd0}});
      send_frame({CHANNELS{12'd4095}});
      send_frame({CHANNELS{12'd0}});
      send_frame({12'd4095, 12'd0, 12'd4095, 12'd0, 12'd4095, 12'd0});

      // zero coefficient kills the output
      drain_packets();
      set_register(CSR_ALPHA, 16'h0000);
      set_register(CSR_HEADER, 16'hFFFF);
      settings_used++;
      send_frame({CHANNELS{12'd4095}});
      send_frame({CHANNELS{12'd0}});
      send_frame({12'hAAA, 12'h555, 12'hAAA, 12'h555, 12'hAAA, 12'h555});

      // smallest nonzero coefficient
      drain_packets();
      set_register(CSR_ALPHA, 16'h0001);
      set_register(CSR_HEADER, 16'h0055);
      settings_used++;
      send_frame({CHANNELS{12'd4095}});
      send_frame({CHANNELS{12'd0}});

      for (int p = 0; p < 5; p++) begin
         drain_packets();
         alpha_pick = (p % 2 == 0) ? 16'($urandom_range(60000, 65535)) : 16'($urandom);
         set_register(CSR_ALPHA, alpha_pick);
         set_register(CSR_HEADER, 16'($urandom));
         if (p == 2)
            set_register(CSR_UNMAPPED_HI, 16'($urandom));
         settings_used++;
         repeat (23) send_frame(random_frame(last_frame));
      end

      drain_packets();
      repeat (16) @(negedge clock);

      $display("Sent %0d sample frames under %0d coefficient/header settings,",
               frames_taken, settings_used);
      $display("checked %0d packet words, %0d mismatches.", words_checked, fault_count);
      if (fault_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
